>>> src/ikhb_pkg.sv
// Shared types, constants and helpers for the integer key hash bucket block.
// No dependencies; used by the mixer, the modulo cells and the top level.
package ikhb_pkg;

   localparam int KEY_W    = 32;
   localparam int MIX_W    = 64;
   localparam int HALF_W   = 32;
   localparam int MULT_W   = 27;
   localparam int DIV_W    = 32;
   localparam int SIZE_W   = 33;
   localparam int SHIFT_N  = 16;

   localparam logic [MULT_W-1:0] HASH_MULT       = 27'h45d9f3b;
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RST  = 33'd1024;
   localparam logic [DIV_W-1:0]  DIVISOR_RST     = 32'd1023;

   // Low partial product is 32 x 27 bits.
   localparam int LO_PROD_W = HALF_W + MULT_W;

   // Data handed from one modulo cell to the next.
   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [MIX_W-1:0] bits;
   } ikhb_div_type;

   function automatic logic [MIX_W-1:0] xor_shift(input logic [MIX_W-1:0] v);
      return v ^ (v >> SHIFT_N);
   endfunction

endpackage

>>> src/ikhb_mix.sv
// Pipelined key mixer: sign extension, two xorshift-multiply rounds and a final xorshift.
// Depends on ikhb_pkg. Each 64-bit multiply is split into two 32 x 27 partial products.
module ikhb_mix
   import ikhb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [KEY_W-1:0] in_key,
   output logic             out_valid,
   output logic [MIX_W-1:0] out_value
);

   logic [3:0] vld_ff;

   logic [MIX_W-1:0]     x0;
   logic [LO_PROD_W-1:0] lo1_ff, lo1_in, lo2_ff, lo2_in;
   logic [HALF_W-1:0]    hi1_ff, hi1_in, hi2_ff, hi2_in;
   logic [MIX_W-1:0]     x1_ff, x1_in, x3_ff, x3_in;

   always_comb begin
      x0     = xor_shift({{(MIX_W-KEY_W){in_key[KEY_W-1]}}, in_key});
      lo1_in = LO_PROD_W'(x0[HALF_W-1:0]) * LO_PROD_W'(HASH_MULT);
      hi1_in = HALF_W'(x0[MIX_W-1:HALF_W] * HALF_W'(HASH_MULT));
      // Only the low half of the high partial product survives the wrap.
      x1_in  = xor_shift({hi1_ff, {HALF_W{1'b0}}} + MIX_W'(lo1_ff));
      lo2_in = LO_PROD_W'(x1_ff[HALF_W-1:0]) * LO_PROD_W'(HASH_MULT);
      hi2_in = HALF_W'(x1_ff[MIX_W-1:HALF_W] * HALF_W'(HASH_MULT));
      x3_in  = xor_shift({hi2_ff, {HALF_W{1'b0}}} + MIX_W'(lo2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo1_ff <= lo1_in;
         hi1_ff <= hi1_in;
         x1_ff  <= x1_in;
         lo2_ff <= lo2_in;
         hi2_ff <= hi2_in;
         x3_ff  <= x3_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_value = x3_ff;

endmodule

>>> src/ikhb_mod_cell.sv
// One step of a restoring remainder: takes the next dividend bit, subtracts when it fits.
// Depends on ikhb_pkg. Cells are chained, one dividend bit per cell.
module ikhb_mod_cell
   import ikhb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [DIV_W-1:0] divisor,
   input  logic             in_valid,
   input  ikhb_div_type     in_data,
   output logic             out_valid,
   output ikhb_div_type     out_data
);

   logic         valid_ff;
   ikhb_div_type data_ff, data_in;
   logic [DIV_W:0] trial;

   always_comb begin
      trial = {in_data.rem, in_data.bits[MIX_W-1]};
      // The remainder stays below the divisor, so one subtract is enough.
      if (trial >= {1'b0, divisor}) begin
         trial = trial - {1'b0, divisor};
      end
      data_in.rem  = trial[DIV_W-1:0];
      data_in.bits = {in_data.bits[MIX_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/integer_key_hash_bucket.sv
// Top level of the integer key hash bucket: mixer, row of modulo cells, output skid.
// Depends on ikhb_pkg, ikhb_mix and ikhb_mod_cell.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | req_valid, req_stall, req_key  | in
//   response| rsp_valid, rsp_stall, rsp_bucket | out
//   csr     | csr_we, csr_table_size         | in
//
// One key is taken every cycle while req_stall is low; a bucket is first offered once its key
// has passed 69 register stages (four mixer stages, 64 modulo cells of one dividend bit
// each, the output register; the first stage loads at the edge that takes its key).
// Reset clears all valid flags and sets the table size to 1024.
// A stalled response fills a one-beat skid register; while it is full the whole
// pipeline holds and req_stall is high, so no beat is lost.
module integer_key_hash_bucket
   import ikhb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KEY_W-1:0]   req_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIV_W-1:0]   rsp_bucket,
   input  logic               csr_we,
   input  logic [SIZE_W-1:0]  csr_table_size
);

   logic [DIV_W-1:0] divisor_ff;
   logic [SIZE_W-1:0] size_m1;

   logic             en;
   logic             mix_valid;
   logic [MIX_W-1:0] mix_value;

   logic         cell_valid [MIX_W+1];
   ikhb_div_type cell_data  [MIX_W+1];

   logic             rsp_valid_ff, skid_valid_ff;
   logic [DIV_W-1:0] rsp_bucket_ff, skid_bucket_ff;
   logic             take;
   logic             pipe_valid;
   logic [DIV_W-1:0] pipe_bucket;

   // Divisor is table size minus one, with sizes below two treated as two.
   assign size_m1 = csr_table_size - SIZE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIVISOR_RST;
      end else if (csr_we) begin
         if (csr_table_size < SIZE_W'(2)) begin
            divisor_ff <= DIV_W'(1);
         end else begin
            divisor_ff <= size_m1[DIV_W-1:0];
         end
      end
   end

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   ikhb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_key    (req_key),
      .out_valid (mix_valid),
      .out_value (mix_value)
   );

   assign cell_valid[0]     = mix_valid;
   assign cell_data[0].rem  = '0;
   assign cell_data[0].bits = mix_value;

   for (genvar i = 0; i < MIX_W; i++) begin : g_cell
      ikhb_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .divisor   (divisor_ff),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   assign pipe_valid  = cell_valid[MIX_W];
   assign pipe_bucket = cell_data[MIX_W].rem;
   assign take        = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_bucket_ff <= skid_bucket_ff;
         end
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_bucket_ff <= pipe_bucket;
         end else begin
            skid_bucket_ff <= pipe_bucket;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bucket = rsp_bucket_ff;

endmodule
